// ===== rtl/hdt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hdt_pkg: shared types and constants of the generational handle table
// Holds the request and response beats, the slot entry layout, the request
// codes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package hdt_pkg;

  localparam int GEN_W    = 32;
  localparam int OBJ_W    = 64;
  localparam int HANDLE_W = 64;
  localparam int TYPE_W   = 4;
  localparam int KIND_W   = 8;

  localparam logic [TYPE_W-1:0] TYPE_FREE    = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_WIDGET  = 4'd1;
  localparam logic [TYPE_W-1:0] TYPE_SURFACE = 4'd2;
  localparam logic [KIND_W-1:0] KIND_NONE    = 8'hFF;
  localparam logic [GEN_W-1:0]  GEN_FIRST    = 32'd1;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_LOOKUP  = 2'd2,
    REQ_REVERSE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_POP,
    ST_MODIFY,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [HANDLE_W-1:0]      handle_in;
    logic [OBJ_W-1:0]         object_in;
    logic [TYPE_W-1:0]        type_in;
    logic signed [KIND_W-1:0] kind_in;
  } hdt_in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]      handle_out;
    logic                     found;
    logic [OBJ_W-1:0]         object_out;
    logic [TYPE_W-1:0]        type_out;
    logic signed [KIND_W-1:0] kind_out;
    logic                     is_window;
  } hdt_out_t;

  // One slot of the table as it sits in memory.
  typedef struct packed {
    logic [OBJ_W-1:0]  obj;
    logic [GEN_W-1:0]  gen;
    logic [TYPE_W-1:0] typ;
    logic [KIND_W-1:0] kind;
  } hdt_entry_t;

  typedef struct packed {
    logic latch_req;   // capture the accepted request
    logic pop;         // read top of recycle stack, shrink it
    logic fresh;       // take the next never-used slot and read it
    logic pop_read;    // read the slot that came off the stack
    logic rd_handle;   // read the slot that the request handle names
    logic scan_start;  // read slot 1
    logic scan_next;   // read the slot after the current one
    logic commit;      // finish the operation on the slot just read
    logic fail;        // finish with the empty result
    logic load_out;    // move the result into the output register
  } hdt_cmd_t;

  typedef struct packed {
    req_e req;
    logic stack_empty;
    logic table_full;
    logic scan_none;   // null object or no slot ever used
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } hdt_sts_t;

endpackage
`default_nettype wire

// ===== rtl/generational_handle_table_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_table_core: generation-tagged handle table
// Allocate, release, lookup and reverse lookup of object handles over a table
// of SLOT_COUNT slots with a stack of recycled slots.
// ----------------------------------------------------------------------------
// The block serves one request at a time and answers each with exactly one
// response beat. A request beat is taken when in_valid_i and in_ready_o are
// both high; in_ready_o is high while the sequencer is idle, and a finished
// response may still sit in the output register while the next request is
// taken. All slot fields live in one single-port-read, single-port-write
// memory with a registered read, so allocate, release and lookup read their
// slot once and every operation writes a slot back at most once. The
// sequencer is ready for the next request at the first edge at which the
// response beat can be taken. Lookup, release and allocate of a never-used
// slot read the slot and commit; allocate of a recycled slot first does the
// registered read of the recycle stack; a full table, a null reverse lookup
// or one before any slot is used goes straight to the result. Reverse lookup
// reads one slot per cycle from slot 1 upward, up to the first live match or
// up to the high-water slot. The result waits in the sequencer while
// out_ready_i holds a previous response back. No clearing pass is needed
// after reset: a fresh slot is read but takes generation 1 whatever the
// memory holds, and handles above the high-water mark are refused.
// ----------------------------------------------------------------------------
module generational_handle_table_core #(
  parameter int SLOT_COUNT = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire hdt_pkg::hdt_in_t in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output hdt_pkg::hdt_out_t     out_rsp_o
);
  import hdt_pkg::*;

  // Command and status groups between the sequencer and the slot datapath.
  hdt_cmd_t cmd;
  hdt_sts_t sts;

  // Sequencer: one request from accept through slot read, update and hand-off.
  hdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: slot memory, recycle stack, high-water mark, output register.
  hdt_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire

// ===== rtl/hdt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hdt_ctrl: operation sequencer of the generational handle table
// Steps one request at a time through slot read, modify and result hand-off.
// ----------------------------------------------------------------------------
module hdt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire hdt_pkg::hdt_sts_t sts_i,
  output hdt_pkg::hdt_cmd_t      cmd_o
);
  import hdt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (sts_i.req)
          REQ_ALLOC: begin
            if (!sts_i.stack_empty) begin
              cmd_o.pop = 1'b1;
              state_d   = ST_POP;
            end else if (!sts_i.table_full) begin
              cmd_o.fresh = 1'b1;
              state_d     = ST_MODIFY;
            end else begin
              cmd_o.fail = 1'b1;
              state_d    = ST_DONE;
            end
          end
          REQ_RELEASE, REQ_LOOKUP: begin
            cmd_o.rd_handle = 1'b1;
            state_d         = ST_MODIFY;
          end
          REQ_REVERSE: begin
            if (sts_i.scan_none) begin
              cmd_o.fail = 1'b1;
              state_d    = ST_DONE;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end
          end
          default: begin
            cmd_o.fail = 1'b1;
            state_d    = ST_DONE;
          end
        endcase
      end
      ST_POP: begin
        cmd_o.pop_read = 1'b1;
        state_d        = ST_MODIFY;
      end
      ST_MODIFY: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_DONE;
      end
      ST_SCAN: begin
        // Commit on a hit, or on the last used slot (a miss then reports empty).
        if (sts_i.scan_hit || sts_i.scan_end) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/hdt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hdt_datapath: slot memory, recycle stack and result registers
// Executes the controller's commands on the slot table and the free stack.
// ----------------------------------------------------------------------------
module hdt_datapath #(
  parameter int SLOT_COUNT = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hdt_pkg::hdt_in_t  in_req_i,
  input  wire hdt_pkg::hdt_cmd_t cmd_i,
  output hdt_pkg::hdt_sts_t      sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hdt_pkg::hdt_out_t      out_rsp_o
);
  import hdt_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int CW = SW + 1;
  localparam logic [SW-1:0] HW_MAX   = SW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(SLOT_COUNT);

  hdt_entry_t slot_mem_q [SLOT_COUNT];
  logic [SW-1:0] stack_mem_q [SLOT_COUNT];

  hdt_in_t       req_q;
  logic [SW-1:0] hw_q, hw_d;
  logic [CW-1:0] cnt_q, cnt_d;
  hdt_entry_t    ent_q;
  logic [SW-1:0] slot_q;
  logic          fresh_q;
  logic          range_ok_q;
  logic [SW-1:0] stk_q;
  hdt_out_t      res_q, res_d;
  hdt_out_t      out_q;
  logic          out_valid_q;

  req_e          req;
  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic          range_ok;
  logic [CW-1:0] cnt_m1;
  logic          wr_en;
  hdt_entry_t    wr_data;
  logic          push_en;
  logic          hnd_ok;
  logic          match;
  logic          ent_ok;
  logic [GEN_W-1:0] gen_alloc;
  logic [GEN_W-1:0] gen_bump;
  hdt_out_t      empty_res;

  assign req    = req_e'(req_q.req_type);
  assign cnt_m1 = cnt_q - CW'(1);

  // Handle names a used slot: upper slot bits clear, not slot 0, not past high water.
  assign range_ok = (req_q.handle_in[31:SW] == '0) && (req_q.handle_in[SW-1:0] != '0) &&
                    (req_q.handle_in[SW-1:0] <= hw_q);

  assign hnd_ok = range_ok_q && (ent_q.gen == req_q.handle_in[63:32]) &&
                  (ent_q.typ != TYPE_FREE);
  assign match  = (ent_q.typ != TYPE_FREE) && (ent_q.obj == req_q.object_in);
  assign ent_ok = (req == REQ_REVERSE) ? match : hnd_ok;

  // A fresh slot has never held a generation; a recycled one is already nonzero.
  assign gen_alloc = (fresh_q || ent_q.gen == '0) ? GEN_FIRST : ent_q.gen;
  assign gen_bump  = (ent_q.gen + GEN_FIRST == '0) ? GEN_FIRST : ent_q.gen + GEN_FIRST;

  always_comb begin
    empty_res            = '0;
    empty_res.kind_out   = KIND_NONE;
  end

  // Read port address select.
  always_comb begin
    rd_en   = cmd_i.fresh | cmd_i.pop_read | cmd_i.rd_handle |
              cmd_i.scan_start | cmd_i.scan_next;
    rd_addr = '0;
    if (cmd_i.fresh) begin
      rd_addr = hw_q + SW'(1);
    end else if (cmd_i.pop_read) begin
      rd_addr = stk_q;
    end else if (cmd_i.rd_handle) begin
      rd_addr = req_q.handle_in[SW-1:0];
    end else if (cmd_i.scan_start) begin
      rd_addr = SW'(1);
    end else if (cmd_i.scan_next) begin
      rd_addr = slot_q + SW'(1);
    end
  end

  // Finish step: write back the slot, push the stack, form the result.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = ent_q;
    push_en = 1'b0;
    res_d   = res_q;
    if (cmd_i.fail) begin
      res_d = empty_res;
    end else if (cmd_i.commit) begin
      res_d = empty_res;
      if (req == REQ_ALLOC) begin
        wr_en            = 1'b1;
        wr_data.obj      = req_q.object_in;
        wr_data.gen      = gen_alloc;
        wr_data.typ      = req_q.type_in;
        wr_data.kind     = req_q.kind_in;
        res_d.handle_out = {gen_alloc, 32'(slot_q)};
        res_d.found      = 1'b1;
      end else if (ent_ok) begin
        if (req == REQ_RELEASE) begin
          wr_en       = 1'b1;
          wr_data.gen = gen_bump;
          wr_data.typ = TYPE_FREE;
          push_en     = (cnt_q < CNT_FULL);
          res_d.found = 1'b1;
        end else begin
          res_d.handle_out = {ent_q.gen, 32'(slot_q)};
          res_d.found      = 1'b1;
          res_d.object_out = ent_q.obj;
          res_d.type_out   = ent_q.typ;
          res_d.kind_out   = ent_q.kind;
          res_d.is_window  = (ent_q.typ == TYPE_WIDGET) || (ent_q.typ == TYPE_SURFACE);
        end
      end
    end
  end

  always_comb begin
    hw_d  = hw_q;
    cnt_d = cnt_q;
    if (cmd_i.fresh) begin
      hw_d = hw_q + SW'(1);
    end
    if (cmd_i.pop) begin
      cnt_d = cnt_m1;
    end else if (push_en) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[slot_q] <= wr_data;
    end
    if (rd_en) begin
      ent_q <= slot_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem_q[cnt_q[SW-1:0]] <= slot_q;
    end
    if (cmd_i.pop) begin
      stk_q <= stack_mem_q[cnt_m1[SW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q <= in_req_i;
    end
    if (rd_en) begin
      slot_q  <= rd_addr;
      fresh_q <= cmd_i.fresh;
    end
    if (cmd_i.rd_handle) begin
      range_ok_q <= range_ok;
    end
    res_q <= res_d;
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hw_q  <= hw_d;
      cnt_q <= cnt_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.req         = req;
  assign sts_o.stack_empty = (cnt_q == '0);
  assign sts_o.table_full  = (hw_q == HW_MAX);
  assign sts_o.scan_none   = (req_q.object_in == '0) || (hw_q == '0);
  assign sts_o.scan_hit    = match;
  assign sts_o.scan_end    = (slot_q == hw_q);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
`default_nettype wire

// ===== dv/tb_generational_handle_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_generational_handle_table_core: self-checking bench of the handle table
// Sends allocate, release, lookup and reverse-lookup beats through the request
// channel, predicts each response from a shadow copy of the table, and checks
// every response beat field by field under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_generational_handle_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import hdt_pkg::*;

  localparam int SLOTS = 256;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_q = 1'b0;
  logic     in_ready_o;
  hdt_in_t  in_beat_q = '0;
  logic     out_valid_o;
  logic     out_ready_q = 1'b0;
  hdt_out_t out_beat;

  generational_handle_table_core #(
    .SLOT_COUNT(SLOTS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_q),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_beat_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_q),
    .out_rsp_o  (out_beat)
  );

  // Shadow copy of the table: slot fields, high-water mark and recycle stack.
  logic [OBJ_W-1:0]  obj_tbl   [SLOTS];
  logic [GEN_W-1:0]  gen_tbl   [SLOTS];
  logic [TYPE_W-1:0] typ_tbl   [SLOTS];
  logic [KIND_W-1:0] kind_tbl  [SLOTS];
  int unsigned       free_stack[SLOTS];
  int unsigned       high_water;
  int unsigned       free_depth;

  hdt_in_t     pending_req_q[$];   // beats waiting to be driven
  hdt_out_t    awaited_rsp_q[$];   // predicted responses, oldest first
  int unsigned issued_cnt;
  int unsigned accepted_cnt;
  int unsigned mismatch_cnt;
  int unsigned in_gap;
  int unsigned out_gap;
  bit          quiet_mode;         // no idling on either side while set
  logic [63:0] obj_pool[8];        // shared objects, so several slots hold one

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Safety net: far beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [63:0] mk_handle(input logic [31:0] gen, input logic [31:0] slot);
    return {gen, slot};
  endfunction

  // Slot that a handle names, or 0 when the handle does not check out:
  // slot out of 1..high_water, generation mismatch, or slot marked free.
  function automatic int unsigned handle_slot(input logic [63:0] h);
    int unsigned s;
    s = h[31:0];
    if (s == 0 || s > high_water) return 0;
    if (gen_tbl[s] != h[63:32]) return 0;
    if (typ_tbl[s] == TYPE_FREE) return 0;
    return s;
  endfunction

  function automatic hdt_out_t slot_report(input int unsigned s);
    hdt_out_t rsp;
    rsp.handle_out = mk_handle(gen_tbl[s], s);
    rsp.found      = 1'b1;
    rsp.object_out = obj_tbl[s];
    rsp.type_out   = typ_tbl[s];
    rsp.kind_out   = kind_tbl[s];
    rsp.is_window  = (typ_tbl[s] == TYPE_WIDGET) || (typ_tbl[s] == TYPE_SURFACE);
    return rsp;
  endfunction

  // Apply one request to the shadow table and return the response it earns.
  function automatic hdt_out_t table_apply(input hdt_in_t rq);
    hdt_out_t    rsp;
    int unsigned s;
    rsp          = '0;
    rsp.kind_out = KIND_NONE;
    s            = 0;
    case (req_e'(rq.req_type))
      REQ_ALLOC: begin
        // Recycled slots first, then the next never-used one; slot 0 stays reserved.
        if (free_depth > 0) begin
          free_depth--;
          s = free_stack[free_depth] % SLOTS;
        end else if (high_water + 1 < SLOTS) begin
          high_water++;
          s = high_water;
        end
        if (s != 0) begin
          obj_tbl[s]  = rq.object_in;
          typ_tbl[s]  = rq.type_in;
          kind_tbl[s] = rq.kind_in;
          if (gen_tbl[s] == '0) gen_tbl[s] = GEN_FIRST;
          rsp.handle_out = mk_handle(gen_tbl[s], s);
          rsp.found      = 1'b1;
        end
      end
      REQ_RELEASE: begin
        s = handle_slot(rq.handle_in);
        if (s != 0) begin
          typ_tbl[s] = TYPE_FREE;
          gen_tbl[s] = gen_tbl[s] + 1;
          if (gen_tbl[s] == '0) gen_tbl[s] = GEN_FIRST;
          if (free_depth < SLOTS) begin
            free_stack[free_depth] = s;
            free_depth++;
          end
          rsp.found = 1'b1;
        end
      end
      REQ_LOOKUP: begin
        s = handle_slot(rq.handle_in);
        if (s != 0) rsp = slot_report(s);
      end
      default: begin
        // Reverse lookup: first live slot holding the object; null finds nothing.
        if (rq.object_in != '0) begin
          for (int unsigned i = 1; i <= high_water && i < SLOTS; i++) begin
            if (typ_tbl[i] != TYPE_FREE && obj_tbl[i] == rq.object_in) begin
              rsp = slot_report(i);
              break;
            end
          end
        end
      end
    endcase
    return rsp;
  endfunction

  // Mostly no gap, some short ones, a few long stretches.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 6);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_cnt < 40)
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_rsp(input hdt_out_t got);
    hdt_out_t want;
    if (awaited_rsp_q.size() == 0) begin
      report_mismatch("unrequested beat", got.handle_out, '0);
    end else begin
      want = awaited_rsp_q.pop_front();
      if (got.handle_out !== want.handle_out)
        report_mismatch("handle_out", got.handle_out, want.handle_out);
      if (got.found !== want.found)
        report_mismatch("found", 64'(got.found), 64'(want.found));
      if (got.object_out !== want.object_out)
        report_mismatch("object_out", got.object_out, want.object_out);
      if (got.type_out !== want.type_out)
        report_mismatch("type_out", 64'(got.type_out), 64'(want.type_out));
      if (got.kind_out !== want.kind_out)
        report_mismatch("kind_out", 64'(got.kind_out), 64'(want.kind_out));
      if (got.is_window !== want.is_window)
        report_mismatch("is_window", 64'(got.is_window), 64'(want.is_window));
    end
  endtask

  // Request driver: predict on every accepted beat, then hold, idle or load
  // the next pending beat. Valid only drops after acceptance.
  always @(posedge clk_i) begin : drive_req
    if (rst_ni) begin
      if (in_valid_q && in_ready_o) begin
        awaited_rsp_q.push_back(table_apply(in_beat_q));
        accepted_cnt++;
      end
      if (!in_valid_q || in_ready_o) begin
        if (in_gap != 0 || pending_req_q.size() == 0) begin
          if (in_gap != 0) in_gap--;
          in_valid_q <= 1'b0;
        end else begin
          in_beat_q  <= pending_req_q.pop_front();
          in_valid_q <= 1'b1;
          in_gap = draw_gap();
        end
      end
    end
  end

  // Response monitor: check each accepted beat, then stall ready at random.
  always @(posedge clk_i) begin : watch_rsp
    if (rst_ni) begin
      if (out_valid_o && out_ready_q) check_rsp(out_beat);
      if (out_gap != 0) begin
        out_gap--;
        out_ready_q <= 1'b0;
      end else begin
        out_ready_q <= 1'b1;
        if ($urandom_range(0, 2) == 0) out_gap = draw_gap();
      end
    end
  end

  task automatic send(input req_e op, input logic [63:0] h, input logic [63:0] o,
                      input logic [3:0] t, input logic [7:0] k);
    hdt_in_t beat;
    beat.req_type  = op;
    beat.handle_in = h;
    beat.object_in = o;
    beat.type_in   = t;
    beat.kind_in   = k;
    pending_req_q.push_back(beat);
    issued_cnt++;
  endtask

  // Wait until the shadow table reflects every beat issued so far.
  task automatic await_sync();
    while (accepted_cnt != issued_cnt) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_live();
    int unsigned live[$];
    for (int unsigned i = 1; i <= high_water; i++)
      if (typ_tbl[i] != TYPE_FREE) live.push_back(i);
    if (live.size() == 0) return 0;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // Mostly live handles, the rest stale, out of range, corrupted or noise.
  function automatic logic [63:0] pick_handle();
    int unsigned r;
    int unsigned s;
    logic [31:0] lo;
    r = $urandom_range(0, 99);
    s = pick_live();
    if (r < 55 && s != 0) return mk_handle(gen_tbl[s], s);
    if (r < 65 && high_water != 0) begin
      s = $urandom_range(1, high_water);
      return mk_handle(gen_tbl[s] - 1, s);
    end
    if (r < 72) return mk_handle($urandom, $urandom_range(high_water + 1, 300));
    if (r < 78) return mk_handle($urandom, 0);
    if (r < 84 && s != 0) return mk_handle(gen_tbl[s] ^ (32'd1 << $urandom_range(0, 31)), s);
    if (r < 90 && s != 0) begin
      lo       = $urandom;
      lo[7:0]  = s[7:0];
      lo[8]    = 1'b1;
      return mk_handle(gen_tbl[s], lo);
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_store_obj();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return obj_pool[$urandom_range(0, 7)];
    if (r < 38) return '0;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_find_obj();
    int unsigned r;
    int unsigned s;
    r = $urandom_range(0, 99);
    s = pick_live();
    if (r < 45 && s != 0) return obj_tbl[s];
    if (r < 60) return obj_pool[$urandom_range(0, 7)];
    if (r < 70) return '0;
    if (r < 80 && high_water != 0) return obj_tbl[$urandom_range(1, high_water)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [3:0] pick_type();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return TYPE_WIDGET;
    if (r < 65) return TYPE_SURFACE;
    if (r < 70) return TYPE_FREE;
    return 4'($urandom_range(3, 15));
  endfunction

  function automatic logic [7:0] pick_kind();
    if ($urandom_range(0, 1) == 0) return KIND_NONE;
    return 8'($urandom_range(0, 127));
  endfunction

  initial begin : stimulus
    int unsigned r;
    int unsigned len;
    int unsigned pct_alloc;
    int unsigned pct_rel;
    int unsigned pct_look;
    logic [63:0] noise_h;
    logic [63:0] noise_o;
    rst_ni <= 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      obj_tbl[i]    = '0;
      gen_tbl[i]    = '0;
      typ_tbl[i]    = TYPE_FREE;
      kind_tbl[i]   = '0;
      free_stack[i] = 0;
    end
    high_water   = 0;
    free_depth   = 0;
    issued_cnt   = 0;
    accepted_cnt = 0;
    mismatch_cnt = 0;
    in_gap       = 0;
    out_gap      = 0;
    quiet_mode   = 1'b0;
    for (int i = 0; i < 8; i++) obj_pool[i] = {$urandom, $urandom} | 64'd1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty table, field extremes, stale and corrupt handles,
    // free-typed slots, recycling with a bumped generation, duplicate objects.
    send(REQ_LOOKUP,  '0, '0, TYPE_FREE, KIND_NONE);               // empty table
    send(REQ_RELEASE, mk_handle(1, 1), '0, TYPE_FREE, KIND_NONE);  // above high water
    send(REQ_REVERSE, '0, '0, TYPE_FREE, KIND_NONE);               // null object
    send(REQ_REVERSE, '0, '1, TYPE_FREE, KIND_NONE);               // nothing used yet
    send(REQ_ALLOC,   '0, '1, TYPE_WIDGET, 8'sd127);               // slot 1
    send(REQ_ALLOC,   '1, 64'd1, TYPE_SURFACE, KIND_NONE);         // slot 2
    send(REQ_ALLOC,   '0, 64'h8000_0000_0000_0000, 4'hF, 8'sd0);   // slot 3
    send(REQ_ALLOC,   '0, 64'h1234, TYPE_FREE, 8'sd5);             // slot 4 reads free
    send(REQ_LOOKUP,  mk_handle(1, 1), '0, TYPE_FREE, KIND_NONE);
    send(REQ_LOOKUP,  mk_handle(1, 2), '0, TYPE_FREE, KIND_NONE);
    send(REQ_LOOKUP,  mk_handle(1, 3), '0, TYPE_FREE, KIND_NONE);
    send(REQ_LOOKUP,  mk_handle(1, 4), '0, TYPE_FREE, KIND_NONE);
    send(REQ_RELEASE, mk_handle(1, 4), '0, TYPE_FREE, KIND_NONE);  // free-typed: refused
    send(REQ_REVERSE, '0, 64'h1234, TYPE_FREE, KIND_NONE);         // only a free slot holds it
    send(REQ_REVERSE, '0, '1, TYPE_FREE, KIND_NONE);               // slot 1
    send(REQ_ALLOC,   '0, '1, 4'd7, 8'sd1);                        // slot 5, same object
    send(REQ_RELEASE, mk_handle(1, 2), '0, TYPE_FREE, KIND_NONE);
    send(REQ_LOOKUP,  mk_handle(1, 2), '0, TYPE_FREE, KIND_NONE);  // stale generation
    send(REQ_RELEASE, mk_handle(1, 2), '0, TYPE_FREE, KIND_NONE);  // double release
    send(REQ_ALLOC,   '0, 64'hA5A5_5A5A_A5A5_5A5A, TYPE_WIDGET, 8'sd3);  // recycled slot 2
    send(REQ_LOOKUP,  mk_handle(2, 2), '0, TYPE_FREE, KIND_NONE);
    send(REQ_RELEASE, mk_handle(1, 1), '0, TYPE_FREE, KIND_NONE);
    send(REQ_REVERSE, '0, '1, TYPE_FREE, KIND_NONE);               // now finds slot 5
    send(REQ_LOOKUP,  64'hFFFF_FFFF_0000_0003, '0, TYPE_FREE, KIND_NONE);
    send(REQ_LOOKUP,  64'h0000_0001_0000_0103, '0, TYPE_FREE, KIND_NONE);

    // Random part in phases: fill to a full table, mix, drain, refill, mix.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       begin len = 320; pct_alloc = 85; pct_rel = 3;  pct_look = 6;  end
        1:       begin len = 300; pct_alloc = 30; pct_rel = 25; pct_look = 25; end
        2:       begin len = 300; pct_alloc = 10; pct_rel = 60; pct_look = 15; end
        3:       begin len = 300; pct_alloc = 70; pct_rel = 10; pct_look = 10; end
        default: begin len = 380; pct_alloc = 35; pct_rel = 30; pct_look = 20; end
      endcase
      for (int n = 0; n < len; n++) begin
        if (n % 100 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
        await_sync();
        r       = $urandom_range(0, 99);
        noise_h = {$urandom, $urandom};
        noise_o = {$urandom, $urandom};
        if (r < pct_alloc)
          send(REQ_ALLOC, noise_h, pick_store_obj(), pick_type(), pick_kind());
        else if (r < pct_alloc + pct_rel)
          send(REQ_RELEASE, pick_handle(), noise_o, pick_type(), pick_kind());
        else if (r < pct_alloc + pct_rel + pct_look)
          send(REQ_LOOKUP, pick_handle(), noise_o, pick_type(), pick_kind());
        else
          send(REQ_REVERSE, noise_h, pick_find_obj(), pick_type(), pick_kind());
      end
    end

    // Drain: all beats accepted, all responses back, then a scan's worth of cycles.
    await_sync();
    while (awaited_rsp_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
